>>> design/prq_pkg.sv
// Package for the priority slot plus ring queue.
// Holds item structs, status and mode codes, the ring entry type and the FSM states.
// No dependencies.
package prq_pkg;

  // Mode codes of an input item
  localparam logic MODE_ENQ = 1'b0;
  localparam logic MODE_DEQ = 1'b1;

  // Status codes of a result item
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_BUSY  = 2'd2;
  localparam logic [1:0] STAT_EMPTY = 2'd3;

  // Register byte address
  localparam logic [1:0] ADDR_STOP_ID = 2'd0;

  typedef struct packed {
    logic        mode;
    logic [31:0] message_id;
    logic [31:0] sequence_number;
    logic [31:0] payload_word0;
    logic [31:0] payload_word1;
    logic        want_high;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] out_message_id;
    logic [31:0] out_sequence_number;
    logic [31:0] out_payload_word0;
    logic [31:0] out_payload_word1;
    logic [4:0]  ring_count;
    logic        stop_pending;
    logic        all_empty;
    logic        ring_full;
  } out_item_t;

  // One stored message
  typedef struct packed {
    logic [31:0] message_id;
    logic [31:0] sequence_number;
    logic [31:0] payload_word1;
    logic [31:0] payload_word0;
  } ring_entry_t;

  // Ring memory strobes
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

endpackage

>>> design/priority_slot_plus_ring_queue_unit.sv
// Top level of the priority slot plus ring queue.
// Depends on prq_pkg, prq_ring_ram and prq_ctrl; holds the configuration register.
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid/in_ready   | prq_pkg::in_item_t
//   out_    | output    | out_valid/out_ready | prq_pkg::out_item_t
//   config  | input     | psel/penable/pwrite | stop_message_id at byte address 0
//
// Enqueues and dequeues served from the high slot are taken back to back while out_ready is high.
// A dequeue from the ring passes through ST_READ, waiting for the registered ring read data.
// A new item enters at the latest at the edge where the previous result is taken.
// Reset (rst_n low, synchronous) empties the slot and ring; no clearing pass.
// A stalled out_ready holds the result and blocks new items once it is full.
module priority_slot_plus_ring_queue_unit #(
  parameter int RING_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  prq_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output prq_pkg::out_item_t  out_item,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [1:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int IDX_W = $clog2(RING_DEPTH);

  logic [31:0]          stop_id_r;
  prq_pkg::mem_ctl_t    mem_ctl;
  logic [IDX_W-1:0]     mem_waddr;
  logic [IDX_W-1:0]     mem_raddr;
  prq_pkg::ring_entry_t mem_wdata;
  prq_pkg::ring_entry_t mem_rdata;

  // Configuration register
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_id_r <= '0;
    end else if (psel && penable && pwrite && (paddr == prq_pkg::ADDR_STOP_ID)) begin
      stop_id_r <= pwdata;
    end
  end

  assign prdata = (paddr == prq_pkg::ADDR_STOP_ID) ? stop_id_r : '0;

  prq_ctrl #(.RING_DEPTH(RING_DEPTH)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .stop_id   (stop_id_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .mem_ctl   (mem_ctl),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  prq_ring_ram #(.RING_DEPTH(RING_DEPTH)) u_ram (
    .clk   (clk),
    .ctl   (mem_ctl),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

>>> design/prq_ring_ram.sv
// Ring storage: one-write, one-read synchronous memory with registered read data.
// Depends on prq_pkg (ring_entry_t, mem_ctl_t).
module prq_ring_ram #(
  parameter int RING_DEPTH = 16
) (
  input  logic                       clk,
  input  prq_pkg::mem_ctl_t          ctl,
  input  logic [$clog2(RING_DEPTH)-1:0] waddr,
  input  prq_pkg::ring_entry_t       wdata,
  input  logic [$clog2(RING_DEPTH)-1:0] raddr,
  output prq_pkg::ring_entry_t       rdata
);

  prq_pkg::ring_entry_t mem_r [RING_DEPTH];
  prq_pkg::ring_entry_t rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> design/prq_ctrl.sv
// Queue control: pointers, high-priority slot, step decode, FSM and result register.
// Depends on prq_pkg; drives the ports of prq_ring_ram.
module prq_ctrl #(
  parameter int RING_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [31:0]                   stop_id,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  prq_pkg::in_item_t             in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output prq_pkg::out_item_t            out_item,
  output prq_pkg::mem_ctl_t             mem_ctl,
  output logic [$clog2(RING_DEPTH)-1:0] mem_waddr,
  output prq_pkg::ring_entry_t          mem_wdata,
  output logic [$clog2(RING_DEPTH)-1:0] mem_raddr,
  input  prq_pkg::ring_entry_t          mem_rdata
);

  localparam int IDX_W = $clog2(RING_DEPTH);
  localparam int PTR_W = IDX_W + 1;
  localparam logic [PTR_W-1:0] FULL_CNT = PTR_W'(RING_DEPTH);

  prq_pkg::state_t      state_r, state_nxt;
  logic [PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic                 high_occ_r, high_occ_nxt;
  prq_pkg::ring_entry_t high_entry_r, high_entry_nxt;
  logic                 out_valid_r, out_valid_nxt;
  prq_pkg::out_item_t   out_r, out_nxt;

  logic                 in_fire;
  logic                 load_rdata;
  logic                 go_read;
  logic                 to_high;
  logic [PTR_W-1:0]     used_now;
  logic [PTR_W-1:0]     used_nxt;
  logic [1:0]           status;
  prq_pkg::ring_entry_t new_entry;
  prq_pkg::ring_entry_t got_entry;

  assign in_fire   = in_valid & in_ready;
  assign used_now  = wr_ptr_r - rd_ptr_r;
  assign to_high   = in_item.want_high | (in_item.message_id == stop_id);
  assign new_entry = '{message_id:      in_item.message_id,
                       sequence_number: in_item.sequence_number,
                       payload_word1:   in_item.payload_word1,
                       payload_word0:   in_item.payload_word0};

  // FSM next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      prq_pkg::ST_IDLE: begin
        if (in_fire && go_read) begin
          state_nxt = prq_pkg::ST_READ;
        end
      end
      prq_pkg::ST_READ: begin
        state_nxt = prq_pkg::ST_IDLE;
      end
      default: state_nxt = prq_pkg::ST_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_ready   = 1'b0;
    load_rdata = 1'b0;
    unique case (state_r)
      prq_pkg::ST_IDLE: begin
        in_ready = !out_valid_r || out_ready;
      end
      prq_pkg::ST_READ: begin
        load_rdata = 1'b1;
      end
      default: begin
        in_ready   = 1'b0;
        load_rdata = 1'b0;
      end
    endcase
  end

  // Step decode: update pointers, high slot and ring strobes
  always_comb begin
    wr_ptr_nxt     = wr_ptr_r;
    rd_ptr_nxt     = rd_ptr_r;
    high_occ_nxt   = high_occ_r;
    high_entry_nxt = high_entry_r;
    status         = prq_pkg::STAT_OK;
    got_entry      = '0;
    go_read        = 1'b0;
    mem_ctl        = '0;
    if (in_fire) begin
      if (in_item.mode == prq_pkg::MODE_ENQ) begin
        if (to_high) begin
          if (high_occ_r) begin
            status = prq_pkg::STAT_BUSY;
          end else begin
            high_occ_nxt   = 1'b1;
            high_entry_nxt = new_entry;
          end
        end else if (used_now == FULL_CNT) begin
          status = prq_pkg::STAT_FULL;
        end else begin
          mem_ctl.wr_en = 1'b1;
          wr_ptr_nxt    = wr_ptr_r + PTR_W'(1);
        end
      end else begin
        if (high_occ_r) begin
          got_entry    = high_entry_r;
          high_occ_nxt = 1'b0;
        end else if (wr_ptr_r != rd_ptr_r) begin
          // message fields arrive from the ring next cycle
          mem_ctl.rd_en = 1'b1;
          go_read       = 1'b1;
          rd_ptr_nxt    = rd_ptr_r + PTR_W'(1);
        end else begin
          status = prq_pkg::STAT_EMPTY;
        end
      end
    end
  end

  assign mem_waddr = wr_ptr_r[IDX_W-1:0];
  assign mem_raddr = rd_ptr_r[IDX_W-1:0];
  assign mem_wdata = new_entry;
  assign used_nxt  = wr_ptr_nxt - rd_ptr_nxt;

  // Result register
  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (in_fire) begin
      out_nxt.status              = status;
      out_nxt.out_message_id      = got_entry.message_id;
      out_nxt.out_sequence_number = got_entry.sequence_number;
      out_nxt.out_payload_word0   = got_entry.payload_word0;
      out_nxt.out_payload_word1   = got_entry.payload_word1;
      out_nxt.ring_count          = 5'(used_nxt);
      out_nxt.stop_pending        = high_occ_nxt;
      out_nxt.all_empty           = !high_occ_nxt && (used_nxt == '0);
      out_nxt.ring_full           = used_nxt == FULL_CNT;
    end else if (load_rdata) begin
      out_nxt.out_message_id      = mem_rdata.message_id;
      out_nxt.out_sequence_number = mem_rdata.sequence_number;
      out_nxt.out_payload_word0   = mem_rdata.payload_word0;
      out_nxt.out_payload_word1   = mem_rdata.payload_word1;
    end
    if ((in_fire && !go_read) || load_rdata) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= prq_pkg::ST_IDLE;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      high_occ_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      high_occ_r  <= high_occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    high_entry_r <= high_entry_nxt;
    out_r        <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

>>> design/prq_checker.sv
// Port-level checks for the priority slot plus ring queue, bound to the top level.
// Depends on prq_pkg.
module prq_port_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input prq_pkg::out_item_t out_item
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // Empty flag agrees with slot and count
  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.all_empty == (!out_item.stop_pending && out_item.ring_count == 5'd0))
    else $error("all_empty disagrees with stop_pending and ring_count");

  // Empty dequeue leaves everything empty and returns no message
  a_empty_deq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == prq_pkg::STAT_EMPTY |->
      out_item.all_empty && out_item.out_message_id == '0)
    else $error("empty status with data or pending entries");

  // Full and busy rejections match the flags
  a_reject_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status == prq_pkg::STAT_FULL ||
                  out_item.status == prq_pkg::STAT_BUSY) |->
      (out_item.status == prq_pkg::STAT_FULL) ? out_item.ring_full : out_item.stop_pending)
    else $error("rejection status without matching flag");

endmodule

bind priority_slot_plus_ring_queue_unit prq_port_checker u_prq_port_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

>>> test/prq_checker.sv
// Checker for the priority slot plus ring queue: predicts each result item and compares it.
// Depends on prq_pkg; watches the in_, out_ and APB configuration ports of the block.
module prq_checker
  import prq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_item,
  input  logic      psel,
  input  logic      penable,
  input  logic      pwrite,
  input  logic      pready,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output int        mismatches,
  output int        results_owed
);

  localparam int PW = $clog2(DEPTH) + 1;

  // Shadow of the queue state and the stop identifier
  logic [31:0]     stop_id = '0;
  logic            slot_full = 1'b0;
  ring_entry_t     slot_msg;
  ring_entry_t     ring_mem [DEPTH];
  logic [PW-1:0]   wr_ptr = '0;
  logic [PW-1:0]   rd_ptr = '0;
  out_item_t       owed_q [$];
  int              errs = 0;

  // One queue access: update the shadow state and build the result item
  function automatic out_item_t apply_access(in_item_t it);
    out_item_t     r;
    ring_entry_t   msg;
    logic [PW-1:0] used;
    logic          got;
    r = '0;
    r.status = STAT_OK;
    got = 1'b0;
    msg.message_id      = it.message_id;
    msg.sequence_number = it.sequence_number;
    msg.payload_word0   = it.payload_word0;
    msg.payload_word1   = it.payload_word1;
    used = wr_ptr - rd_ptr;
    if (it.mode == MODE_ENQ) begin
      // stop identifier always goes to the high slot
      if (it.want_high || it.message_id == stop_id) begin
        if (slot_full) begin
          r.status = STAT_BUSY;
        end else begin
          slot_full = 1'b1;
          slot_msg = msg;
        end
      end else if (used >= PW'(DEPTH)) begin
        r.status = STAT_FULL;
      end else begin
        ring_mem[wr_ptr[PW-2:0]] = msg;
        wr_ptr = wr_ptr + PW'(1);
      end
    end else if (slot_full) begin
      msg = slot_msg;
      slot_full = 1'b0;
      got = 1'b1;
    end else if (wr_ptr != rd_ptr) begin
      msg = ring_mem[rd_ptr[PW-2:0]];
      rd_ptr = rd_ptr + PW'(1);
      got = 1'b1;
    end else begin
      r.status = STAT_EMPTY;
    end
    if (got) begin
      r.out_message_id      = msg.message_id;
      r.out_sequence_number = msg.sequence_number;
      r.out_payload_word0   = msg.payload_word0;
      r.out_payload_word1   = msg.payload_word1;
    end
    used = wr_ptr - rd_ptr;
    r.ring_count   = 5'(used);
    r.stop_pending = slot_full;
    r.all_empty    = !slot_full && used == '0;
    r.ring_full    = used >= PW'(DEPTH);
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errs++;
    end
  endtask

  // Track config writes, queue expectations on accepted items, compare results
  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      stop_id = '0;
      slot_full = 1'b0;
      slot_msg = '0;
      wr_ptr = '0;
      rd_ptr = '0;
      owed_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == ADDR_STOP_ID)
        stop_id = pwdata;
      if (out_valid && out_ready) begin
        if (owed_q.size() == 0) begin
          $error("result item with no expectation waiting");
          errs++;
        end else begin
          want = owed_q.pop_front();
          check_field("status", 32'(want.status), 32'(out_item.status));
          check_field("out_message_id", want.out_message_id, out_item.out_message_id);
          check_field("out_sequence_number", want.out_sequence_number,
                      out_item.out_sequence_number);
          check_field("out_payload_word0", want.out_payload_word0,
                      out_item.out_payload_word0);
          check_field("out_payload_word1", want.out_payload_word1,
                      out_item.out_payload_word1);
          check_field("ring_count", 32'(want.ring_count), 32'(out_item.ring_count));
          check_field("stop_pending", 32'(want.stop_pending), 32'(out_item.stop_pending));
          check_field("all_empty", 32'(want.all_empty), 32'(out_item.all_empty));
          check_field("ring_full", 32'(want.ring_full), 32'(out_item.ring_full));
        end
      end
      if (in_valid && in_ready)
        owed_q.push_back(apply_access(in_item));
    end
    mismatches <= errs;
    results_owed <= owed_q.size();
  end

endmodule

>>> test/priority_slot_plus_ring_queue_unit_tb.sv
// Testbench top for the priority slot plus ring queue unit: clock, reset, stimulus, verdict.
// Depends on prq_pkg, priority_slot_plus_ring_queue_unit and prq_checker.
module priority_slot_plus_ring_queue_unit_tb;
  import prq_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RAND_PER_PHASE = 258;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  in_item_t    in_item = '0;
  logic        in_ready;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int          tx_idle_pct = 18;
  int          rx_idle_pct = 54;
  int          quiet_cycles = 0;
  int          mismatches;
  int          results_owed;
  logic [31:0] stop_id = '0;

  priority_slot_plus_ring_queue_unit #(.RING_DEPTH(16)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  prq_checker #(.DEPTH(16)) queue_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .mismatches(mismatches), .results_owed(results_owed)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver stalls at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Watchdog: too long without any item or register write moving
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic in_item_t make_msg(logic m, logic [31:0] id, logic [31:0] seq,
                                        logic [31:0] w0, logic [31:0] w1, logic hi);
    in_item_t it;
    it.mode = m;
    it.message_id = id;
    it.sequence_number = seq;
    it.payload_word0 = w0;
    it.payload_word1 = w1;
    it.want_high = hi;
    return it;
  endfunction

  // Offer one item, with random idle cycles ahead of it; returns at the accepting edge
  task automatic push_item(in_item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop offering and wait for every owed result
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (4) @(posedge clk);
  endtask

  // APB write of the stop identifier: setup cycle then access cycle
  task automatic write_stop(logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_STOP_ID;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    stop_id = value;
  endtask

  initial begin
    int          enq_pct;
    in_item_t    it;
    logic [31:0] new_stop;
    enq_pct = 50;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty dequeue with junk fields, stop id forced high, busy slot
    push_item(make_msg(MODE_DEQ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                       32'hFFFF_FFFF, 1'b1));
    push_item(make_msg(MODE_ENQ, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 1'b0));
    push_item(make_msg(MODE_ENQ, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0, 1'b1));
    push_item(make_msg(MODE_DEQ, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0));
    // fill the ring, last one overflows
    for (int i = 0; i < 17; i++)
      push_item(make_msg(MODE_ENQ, (i % 2) ? 32'hFFFF_FFFF : 32'h5A5A_0000 + i,
                         ~(32'h1 << i), 32'h1 << (i + 8),
                         (i % 2) ? 32'h0 : 32'hFFFF_FFFF, 1'b0));
    // high slot still free while ring is full, then drain slot before ring
    push_item(make_msg(MODE_ENQ, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                       32'hFFFF_FFFF, 1'b1));
    push_item(make_msg(MODE_DEQ, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0));
    push_item(make_msg(MODE_DEQ, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0));

    // Random phases: new stop id each phase, new idle mix every second phase
    for (int p = 0; p < 6; p++) begin
      drain();
      case (p / 2)
        0: begin
          tx_idle_pct = 18;
          rx_idle_pct = 54;
        end
        1: begin
          tx_idle_pct = 54;
          rx_idle_pct = 18;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      case (p)
        0: new_stop = 32'hFFFF_FFFF;
        2: new_stop = 32'h0;
        3: new_stop = 32'h1;
        5: new_stop = 32'h8000_0000;
        default: new_stop = $urandom;
      endcase
      write_stop(new_stop);
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        // vary the enqueue share so the ring swings between empty and full
        if (n % 40 == 0) begin
          case ($urandom_range(3))
            0: enq_pct = 20;
            1: enq_pct = 50;
            2: enq_pct = 75;
            default: enq_pct = 92;
          endcase
        end
        it.mode = ($urandom_range(99) < enq_pct) ? MODE_ENQ : MODE_DEQ;
        case ($urandom_range(7))
          0: it.message_id = stop_id;
          1: it.message_id = stop_id ^ (32'h1 << $urandom_range(31));
          default: it.message_id = $urandom;
        endcase
        it.sequence_number = $urandom;
        it.payload_word0 = $urandom;
        it.payload_word1 = $urandom;
        it.want_high = ($urandom_range(99) < 15);
        push_item(it);
      end
    end

    drain();
    repeat (4) @(posedge clk);
    if (mismatches == 0 && results_owed == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
